>>> hdl/ggx_pkg.sv
// Shared constants, types and pipeline depths for the GGX microfacet evaluation unit.
`default_nettype none

package ggx_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int ALPHA_W            = 15;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 15'd8192;

    // 2^32 / pi, rounded.
    localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
    // Internal cap of the distribution value, 2^48.
    localparam logic [48:0] D_CAP      = 49'h1_0000_0000_0000;
    localparam logic [15:0] ONE_Q15    = 16'd32768;
    localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;

    localparam int NDF_DIV_STEPS = 48;
    localparam int ISQRT_STEPS   = 31;
    localparam int G1_DIV_STEPS  = 16;

    // Register stages from the input register to the last register of each path.
    localparam int NDF_LAT = 7 + NDF_DIV_STEPS + 2;
    localparam int G1_LAT  = 4 + ISQRT_STEPS + 1 + G1_DIV_STEPS + 1;
    // The G product register sits right after the G1 units; the rest is padding.
    localparam int G_PAD   = NDF_LAT - G1_LAT - 1;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } vec15_t;

    typedef struct packed {
        logic zero;
        logic cap;
    } ndf_ctl_t;

    typedef struct packed {
        logic vy_zero;
        logic tan_zero;
        logic back;
        logic den_zero;
    } g1_ctl_t;

endpackage

`default_nettype wire

>>> hdl/ggx_dly.sv
// Enabled register delay line used to align the shadowing path with the distribution path.
`default_nettype none

module ggx_dly #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 3
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
        end
    end

    for (genvar i = 1; i < DEPTH; i++) begin : g_tap
        always_ff @(posedge aclk) begin
            if (en) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

>>> hdl/ggx_g1.sv
// Pipelined Smith G1 term for one direction: dot sign, radicand, square root and divider.
`default_nettype none

module ggx_g1 #(
    parameter int COMPONENT_BITS = ggx_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic [2:0][COMPONENT_BITS-1:0]      v_mag,
    input  wire logic [2:0]                          v_neg,
    input  wire logic [2:0][COMPONENT_BITS-1:0]      h_mag,
    input  wire logic [2:0]                          h_neg,
    input  wire ggx_pkg::vec15_t                     v15,
    input  wire logic [ggx_pkg::ALPHA_W-1:0]         alpha,
    output logic      [15:0]                         g1
);

    localparam int PW  = 2 * COMPONENT_BITS;
    localparam int SW  = PW + 2;
    localparam int ISQ = ggx_pkg::ISQRT_STEPS;
    localparam int DVS = ggx_pkg::G1_DIV_STEPS;

    // Stage 1: products and squares.
    logic [2:0][PW-1:0] prod_reg;
    logic [2:0]         same_reg;
    logic               vneg_y1_reg;
    logic [30:0]        sqx_reg, sqy1_reg, sqz_reg;
    logic [29:0]        a2_1_reg;
    logic [15:0]        y1_reg;
    ggx_pkg::g1_ctl_t   ctl1_reg;

    logic [31:0] sqx_full, sqy_full, sqz_full;

    always_comb begin
        sqx_full = {16'b0, v15.x} * {16'b0, v15.x};
        sqy_full = {16'b0, v15.y} * {16'b0, v15.y};
        sqz_full = {16'b0, v15.z} * {16'b0, v15.z};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= PW'(v_mag[i]) * PW'(h_mag[i]);
                same_reg[i] <= (v_neg[i] == h_neg[i]);
            end
            vneg_y1_reg       <= v_neg[1];
            sqx_reg           <= sqx_full[30:0];
            sqy1_reg          <= sqy_full[30:0];
            sqz_reg           <= sqz_full[30:0];
            a2_1_reg          <= 30'(alpha) * 30'(alpha);
            y1_reg            <= v15.y;
            ctl1_reg.vy_zero  <= (v_mag[1] == '0);
            ctl1_reg.tan_zero <= (v_mag[0] == '0) && (v_mag[2] == '0);
            ctl1_reg.back     <= 1'b0;
            ctl1_reg.den_zero <= 1'b0;
        end
    end

    // Stage 2: dot product halves and tangent sum.
    logic [SW-1:0]    pos_reg, neg_reg;
    logic             vneg_y2_reg;
    logic [31:0]      sxz_reg;
    logic [30:0]      sqy2_reg;
    logic [29:0]      a2_2_reg;
    logic [15:0]      y2_reg;
    ggx_pkg::g1_ctl_t ctl2_reg;

    logic [SW-1:0] pos_sum, neg_sum;

    always_comb begin
        pos_sum = '0;
        neg_sum = '0;
        for (int i = 0; i < 3; i++) begin
            if (same_reg[i]) begin
                pos_sum = pos_sum + SW'(prod_reg[i]);
            end else begin
                neg_sum = neg_sum + SW'(prod_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg     <= pos_sum;
            neg_reg     <= neg_sum;
            vneg_y2_reg <= vneg_y1_reg;
            sxz_reg     <= 32'(sqx_reg) + 32'(sqz_reg);
            sqy2_reg    <= sqy1_reg;
            a2_2_reg    <= a2_1_reg;
            y2_reg      <= y1_reg;
            ctl2_reg    <= ctl1_reg;
        end
    end

    // Stage 3: backfacing test and roughness-weighted tangent term.
    logic [61:0]      m_reg;
    logic [30:0]      sqy3_reg;
    logic [15:0]      y3_reg;
    ggx_pkg::g1_ctl_t ctl3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg             <= 62'(a2_2_reg) * 62'(sxz_reg);
            sqy3_reg          <= sqy2_reg;
            y3_reg            <= y2_reg;
            ctl3_reg.vy_zero  <= ctl2_reg.vy_zero;
            ctl3_reg.tan_zero <= ctl2_reg.tan_zero;
            ctl3_reg.back     <= (pos_reg != neg_reg) && ((pos_reg < neg_reg) != vneg_y2_reg);
            ctl3_reg.den_zero <= ctl2_reg.den_zero;
        end
    end

    // Stage 4 and the square root steps.
    logic [62:0]      isq_n_reg   [0:ISQ];
    logic [62:0]      isq_res_reg [0:ISQ];
    logic [15:0]      isq_y_reg   [0:ISQ];
    ggx_pkg::g1_ctl_t isq_ctl_reg [0:ISQ];

    always_ff @(posedge aclk) begin
        if (en) begin
            isq_n_reg[0]   <= 63'({sqy3_reg, 28'b0}) + 63'(m_reg);
            isq_res_reg[0] <= '0;
            isq_y_reg[0]   <= y3_reg;
            isq_ctl_reg[0] <= ctl3_reg;
        end
    end

    for (genvar i = 0; i < ISQ; i++) begin : g_isq
        localparam logic [62:0] BIT = 63'(1) << (2 * (ISQ - 1 - i));
        logic [62:0] trial;
        logic        take;

        always_comb begin
            trial = isq_res_reg[i] + BIT;
            take  = (isq_n_reg[i] >= trial);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (take) begin
                    isq_n_reg[i+1]   <= isq_n_reg[i] - trial;
                    isq_res_reg[i+1] <= (isq_res_reg[i] >> 1) + BIT;
                end else begin
                    isq_n_reg[i+1]   <= isq_n_reg[i];
                    isq_res_reg[i+1] <= isq_res_reg[i] >> 1;
                end
                isq_y_reg[i+1]   <= isq_y_reg[i];
                isq_ctl_reg[i+1] <= isq_ctl_reg[i];
            end
        end
    end

    // Denominator stage, then the restoring divider over the quotient bits.
    logic [31:0]      dv_rem_reg [0:DVS];
    logic [31:0]      dv_den_reg [0:DVS];
    logic [15:0]      dv_q_reg   [0:DVS];
    ggx_pkg::g1_ctl_t dv_ctl_reg [0:DVS];

    logic [31:0] den_sum;

    always_comb begin
        den_sum = 32'({isq_y_reg[ISQ], 14'b0}) + isq_res_reg[ISQ][31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rem_reg[0]          <= 32'({isq_y_reg[ISQ], 14'b0});
            dv_den_reg[0]          <= den_sum;
            dv_q_reg[0]            <= '0;
            dv_ctl_reg[0].vy_zero  <= isq_ctl_reg[ISQ].vy_zero;
            dv_ctl_reg[0].tan_zero <= isq_ctl_reg[ISQ].tan_zero;
            dv_ctl_reg[0].back     <= isq_ctl_reg[ISQ].back;
            dv_ctl_reg[0].den_zero <= (den_sum == '0);
        end
    end

    for (genvar i = 0; i < DVS; i++) begin : g_div
        logic [32:0] rem2, diff;
        logic        ge;

        always_comb begin
            rem2 = {dv_rem_reg[i], 1'b0};
            diff = rem2 - {1'b0, dv_den_reg[i]};
            ge   = (rem2 >= {1'b0, dv_den_reg[i]});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[i+1] <= ge ? diff[31:0] : rem2[31:0];
                dv_den_reg[i+1] <= dv_den_reg[i];
                dv_q_reg[i+1]   <= {dv_q_reg[i][14:0], ge};
                dv_ctl_reg[i+1] <= dv_ctl_reg[i];
            end
        end
    end

    // Final selection of the special cases.
    logic [15:0] g1_reg;
    logic [15:0] g1_next;

    always_comb begin
        priority if (dv_ctl_reg[DVS].vy_zero) begin
            g1_next = '0;
        end else if (dv_ctl_reg[DVS].back) begin
            g1_next = '0;
        end else if (dv_ctl_reg[DVS].tan_zero || dv_ctl_reg[DVS].den_zero) begin
            g1_next = ggx_pkg::ONE_Q15;
        end else begin
            g1_next = dv_q_reg[DVS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g1_reg <= g1_next;
        end
    end

    assign g1 = g1_reg;

endmodule

`default_nettype wire

>>> hdl/ggx_ndf.sv
// Pipelined GGX distribution D and pdf: denominator, normalization, long divider, scaling.
`default_nettype none

module ggx_ndf (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire ggx_pkg::vec15_t             h15,
    input  wire logic                        hy_nz,
    input  wire logic [ggx_pkg::ALPHA_W-1:0] alpha,
    output logic      [31:0]                 ndf_value,
    output logic      [31:0]                 pdf_value
);

    localparam int DVS  = ggx_pkg::NDF_DIV_STEPS;
    localparam int NW   = 61;
    localparam int WW   = NW + 72;
    localparam int TW   = WW - DVS;

    // N1: squares.
    logic [30:0]       sqx_reg, sqy_reg, sqz_reg;
    logic [29:0]       a2_reg;
    logic [15:0]       hy1_reg;
    ggx_pkg::ndf_ctl_t ctl1_reg;
    logic [31:0]       sqx_full, sqy_full, sqz_full;

    always_comb begin
        sqx_full = {16'b0, h15.x} * {16'b0, h15.x};
        sqy_full = {16'b0, h15.y} * {16'b0, h15.y};
        sqz_full = {16'b0, h15.z} * {16'b0, h15.z};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg       <= sqx_full[30:0];
            sqy_reg       <= sqy_full[30:0];
            sqz_reg       <= sqz_full[30:0];
            a2_reg        <= 30'(alpha) * 30'(alpha);
            hy1_reg       <= h15.y;
            ctl1_reg.zero <= !hy_nz || (alpha == '0);
            ctl1_reg.cap  <= 1'b0;
        end
    end

    // N2: alpha-weighted normal term and numerator.
    logic [NW-1:0]     t1_reg, nn2_reg;
    logic [31:0]       sxz_reg;
    logic [15:0]       hy2_reg;
    ggx_pkg::ndf_ctl_t ctl2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg   <= NW'(a2_reg) * NW'(sqy_reg);
            nn2_reg  <= NW'(a2_reg) * NW'(ggx_pkg::INV_PI_Q32);
            sxz_reg  <= 32'(sqx_reg) + 32'(sqz_reg);
            hy2_reg  <= hy1_reg;
            ctl2_reg <= ctl1_reg;
        end
    end

    // N3: denominator base Q.
    logic [NW-1:0]     q_reg, nn3_reg;
    logic [15:0]       hy3_reg;
    ggx_pkg::ndf_ctl_t ctl3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg    <= t1_reg + NW'({sxz_reg, 28'b0});
            nn3_reg  <= nn2_reg;
            hy3_reg  <= hy2_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    // N4: keep the top 32 bits of Q.
    logic [6:0] q_len;
    logic [4:0] q_sh;

    always_comb begin
        q_len = '0;
        for (int i = 0; i < NW; i++) begin
            if (q_reg[i]) begin
                q_len = 7'(i + 1);
            end
        end
        q_sh = (q_len > 7'd32) ? 5'(q_len - 7'd32) : 5'd0;
    end

    logic [31:0]       qm_reg;
    logic [6:0]        k4_reg;
    logic [NW-1:0]     nn4_reg;
    logic [15:0]       hy4_reg;
    ggx_pkg::ndf_ctl_t ctl4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            qm_reg        <= 32'(q_reg >> q_sh);
            k4_reg        <= 7'd72 - 7'({q_sh, 1'b0});
            nn4_reg       <= nn3_reg;
            hy4_reg       <= hy3_reg;
            ctl4_reg.zero <= ctl3_reg.zero;
            ctl4_reg.cap  <= (q_reg == '0);
        end
    end

    // N5: divisor p = Qm^2.
    logic [63:0]       p5_reg;
    logic [6:0]        k5_reg;
    logic [NW-1:0]     nn5_reg;
    logic [15:0]       hy5_reg;
    ggx_pkg::ndf_ctl_t ctl5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p5_reg   <= 64'(qm_reg) * 64'(qm_reg);
            k5_reg   <= k4_reg;
            nn5_reg  <= nn4_reg;
            hy5_reg  <= hy4_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    // N6: align the dividend n * 2^k.
    logic [WW-1:0]     w_shift;
    logic [TW-1:0]     t6_reg;
    logic [DVS-1:0]    low6_reg;
    logic [63:0]       p6_reg;
    logic [15:0]       hy6_reg;
    ggx_pkg::ndf_ctl_t ctl6_reg;

    always_comb begin
        w_shift = WW'(nn5_reg) << k5_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t6_reg   <= w_shift[WW-1:DVS];
            low6_reg <= w_shift[DVS-1:0];
            p6_reg   <= p5_reg;
            hy6_reg  <= hy5_reg;
            ctl6_reg <= ctl5_reg;
        end
    end

    // N7 and the divider: a quotient of 2^48 or more saturates.
    logic [63:0]       dv_rem_reg [0:DVS];
    logic [DVS-1:0]    dv_low_reg [0:DVS];
    logic [63:0]       dv_p_reg   [0:DVS];
    logic [DVS-1:0]    dv_q_reg   [0:DVS];
    logic [15:0]       dv_hy_reg  [0:DVS];
    ggx_pkg::ndf_ctl_t dv_ctl_reg [0:DVS];

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rem_reg[0]      <= t6_reg[63:0];
            dv_low_reg[0]      <= low6_reg;
            dv_p_reg[0]        <= p6_reg;
            dv_q_reg[0]        <= '0;
            dv_hy_reg[0]       <= hy6_reg;
            dv_ctl_reg[0].zero <= ctl6_reg.zero;
            dv_ctl_reg[0].cap  <= ctl6_reg.cap || (|t6_reg[TW-1:64]) || (t6_reg[63:0] >= p6_reg);
        end
    end

    for (genvar i = 0; i < DVS; i++) begin : g_div
        logic [64:0] rem2, diff;
        logic        ge;

        always_comb begin
            rem2 = {dv_rem_reg[i], dv_low_reg[i][DVS-1]};
            diff = rem2 - {1'b0, dv_p_reg[i]};
            ge   = (rem2 >= {1'b0, dv_p_reg[i]});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[i+1] <= ge ? diff[63:0] : rem2[63:0];
                dv_low_reg[i+1] <= {dv_low_reg[i][DVS-2:0], 1'b0};
                dv_p_reg[i+1]   <= dv_p_reg[i];
                dv_q_reg[i+1]   <= {dv_q_reg[i][DVS-2:0], ge};
                dv_hy_reg[i+1]  <= dv_hy_reg[i];
                dv_ctl_reg[i+1] <= dv_ctl_reg[i];
            end
        end
    end

    // D with its special cases.
    logic [48:0] d_reg;
    logic [15:0] hyd_reg;
    logic [48:0] d_next;

    always_comb begin
        priority if (dv_ctl_reg[DVS].zero) begin
            d_next = '0;
        end else if (dv_ctl_reg[DVS].cap) begin
            d_next = ggx_pkg::D_CAP;
        end else begin
            d_next = {1'b0, dv_q_reg[DVS]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg   <= d_next;
            hyd_reg <= dv_hy_reg[DVS];
        end
    end

    // pdf scaling and output saturation.
    logic [64:0] pdf_prod;
    logic [49:0] pdf_full;
    logic [31:0] ndf_reg, pdf_reg;

    always_comb begin
        pdf_prod = 65'(d_reg) * 65'(hyd_reg);
        pdf_full = pdf_prod[64:15];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ndf_reg <= (|d_reg[48:32]) ? ggx_pkg::SAT32 : d_reg[31:0];
            pdf_reg <= (|pdf_full[49:32]) ? ggx_pkg::SAT32 : pdf_full[31:0];
        end
    end

    assign ndf_value = ndf_reg;
    assign pdf_value = pdf_reg;

endmodule

`default_nettype wire

>>> hdl/ggx_microfacet_eval_unit.sv
// Top level of the GGX microfacet evaluation unit: input decode, path alignment, handshake.
// Throughput: one item per cycle; the long dividers and square roots are unrolled stages.
// A stalled output freezes the whole pipeline; no item is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and sets alpha to 0.5.
`default_nettype none

module ggx_microfacet_eval_unit #(
    parameter int  COMPONENT_BITS = ggx_pkg::COMPONENT_BITS_DEF,
    localparam int S_TDATA_W      = ((9 * COMPONENT_BITS + 7) / 8) * 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // Roughness register, unsigned Q1.14.
    input  wire logic                        cfg_wr_en,
    input  wire logic [ggx_pkg::ALPHA_W-1:0] cfg_wr_data,
    // Input item, lowest bits first: wo_x, wo_y, wo_z, wi_x, wi_y, wi_z, wh_x, wh_y, wh_z.
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [S_TDATA_W-1:0]        s_tdata,
    // Result item, lowest bits first: ndf_value, shadowing, pdf_value.
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [79:0]                      m_tdata
);

    localparam int CB      = COMPONENT_BITS;
    localparam int NF      = 9;
    localparam int EXT     = CB + 16;
    localparam int DOWN_SH = (CB > 16) ? (CB - 16) : 0;
    localparam int UP_SH   = (CB < 16) ? (16 - CB) : 0;
    localparam int LAT     = ggx_pkg::NDF_LAT;

    // The user must change the roughness register only while the pipeline is empty, and
    // the block itself has no guard for this; every stage reads it directly.
    logic [ggx_pkg::ALPHA_W-1:0] alpha_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ggx_pkg::ALPHA_RESET;
        end else if (cfg_wr_en) begin
            alpha_reg <= cfg_wr_data;
        end
    end

    // One valid bit per pipeline stage. Stage 0 is the input register and stage
    // LAT holds the result item. The pipeline moves as a whole whenever the
    // result register is empty or being taken.
    logic [LAT:0] valid_reg;
    logic         adv;

    assign adv      = !valid_reg[LAT] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[LAT-1:0], s_tvalid};
        end
    end

    logic [NF*CB-1:0] in_data_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_data_reg <= s_tdata[NF*CB-1:0];
        end
    end

    // Decode each component into sign, magnitude and a Q1.15 magnitude.
    logic [CB-1:0] mag_f [0:NF-1];
    logic          neg_f [0:NF-1];
    logic [15:0]   m15_f [0:NF-1];

    for (genvar f = 0; f < NF; f++) begin : g_dec
        logic [CB-1:0]  raw;
        logic [EXT-1:0] scaled;

        always_comb begin
            raw      = in_data_reg[f*CB +: CB];
            neg_f[f] = raw[CB-1];
            mag_f[f] = raw[CB-1] ? CB'(~raw + CB'(1)) : raw;
            scaled   = (EXT'(mag_f[f]) >> DOWN_SH) << UP_SH;
            m15_f[f] = scaled[15:0];
        end
    end

    ggx_pkg::vec15_t            wo15, wi15, wh15;
    logic [2:0][CB-1:0]         wo_mag, wi_mag, wh_mag;
    logic [2:0]                 wo_neg, wi_neg, wh_neg;

    always_comb begin
        wo15.x = m15_f[0];
        wo15.y = m15_f[1];
        wo15.z = m15_f[2];
        wi15.x = m15_f[3];
        wi15.y = m15_f[4];
        wi15.z = m15_f[5];
        wh15.x = m15_f[6];
        wh15.y = m15_f[7];
        wh15.z = m15_f[8];
        for (int i = 0; i < 3; i++) begin
            wo_mag[i] = mag_f[i];
            wo_neg[i] = neg_f[i];
            wi_mag[i] = mag_f[3+i];
            wi_neg[i] = neg_f[3+i];
            wh_mag[i] = mag_f[6+i];
            wh_neg[i] = neg_f[6+i];
        end
    end

    // Distribution and pdf path; its last register is the result register.
    logic [31:0] ndf_value, pdf_value;

    ggx_ndf u_ndf (
        .aclk      (aclk),
        .en        (adv),
        .h15       (wh15),
        .hy_nz     (wh_mag[1] != '0),
        .alpha     (alpha_reg),
        .ndf_value (ndf_value),
        .pdf_value (pdf_value)
    );

    // Smith shadowing for the outgoing and the incoming direction in parallel.
    logic [15:0] g1_wo, g1_wi;

    ggx_g1 #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_g1_wo (
        .aclk  (aclk),
        .en    (adv),
        .v_mag (wo_mag),
        .v_neg (wo_neg),
        .h_mag (wh_mag),
        .h_neg (wh_neg),
        .v15   (wo15),
        .alpha (alpha_reg),
        .g1    (g1_wo)
    );

    ggx_g1 #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_g1_wi (
        .aclk  (aclk),
        .en    (adv),
        .v_mag (wi_mag),
        .v_neg (wi_neg),
        .h_mag (wh_mag),
        .h_neg (wh_neg),
        .v15   (wi15),
        .alpha (alpha_reg),
        .g1    (g1_wi)
    );

    // The G1 product never exceeds 1.0, so the Q1.15 result fits in 16 bits.
    logic [31:0] g_prod;
    logic [15:0] g_reg;
    logic [15:0] shadowing;

    assign g_prod = 32'(g1_wo) * 32'(g1_wi);

    always_ff @(posedge aclk) begin
        if (adv) begin
            g_reg <= g_prod[30:15];
        end
    end

    // The shadowing path is shorter; G_PAD delay registers line it up with D.
    ggx_dly #(
        .WIDTH (16),
        .DEPTH (ggx_pkg::G_PAD)
    ) u_g_dly (
        .aclk (aclk),
        .en   (adv),
        .din  (g_reg),
        .dout (shadowing)
    );

    assign m_tdata = {pdf_value, shadowing, ndf_value};

    // The shadowing product is a probability and never exceeds 1.0.
    a_shadow_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[47:32] <= ggx_pkg::ONE_Q15))
        else $error("shadowing above one");

    // pdf is D scaled by |h.y| <= 1, so it never exceeds D.
    a_pdf_le_ndf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[79:48] <= m_tdata[31:0]))
        else $error("pdf larger than distribution");

    // Input is only refused while a result item is waiting.
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input refused without a waiting result");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
